[sv/adaptive_collection_threshold_defines.svh]
// Assertion macros used by the adaptive collection threshold datapath
`ifndef ADAPTIVE_COLLECTION_THRESHOLD_DEFINES_SVH
`define ADAPTIVE_COLLECTION_THRESHOLD_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset-qualified
`define ACT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, reset-qualified
`define ACT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACT_ASSERT_IMP(lbl, ante, cons, msg)
`define ACT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[sv/act_pkg.sv]
// Shared types, constants and register codes for the adaptive collection threshold
package act_pkg;

  // History ring and byte-count sizing
  localparam int HIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int BYTE_W     = 32;
  localparam int TRIG_W     = 5;
  localparam int CMP_W      = (CNT_W > TRIG_W) ? CNT_W : TRIG_W;

  // Remainder unit: dividend is total + step - threshold
  localparam int DIV_W  = BYTE_W + 1;
  localparam int BCNT_W = $clog2(DIV_W);
  localparam int M_W    = BYTE_W + 2;
  localparam int SUM_W  = BYTE_W + 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_W   = 1 + 2 * BYTE_W;
  localparam int IN_TW  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W  = 1 + BYTE_W + 2 + 2;
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAISE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START = 3'd6;

  // Mode codes; the unused codes 2 and 3 behave as adaptive always-collect
  localparam logic [1:0] MODE_BARRIER = 2'd0;
  localparam logic [1:0] MODE_ALWAYS  = 2'd1;

  // Reset values of the configuration registers
  localparam logic [1:0]        MODE_RST  = MODE_BARRIER;
  localparam logic [BYTE_W-1:0] MIN_RST   = BYTE_W'(1048576);
  localparam logic [BYTE_W-1:0] MAX_RST   = BYTE_W'(268435456);
  localparam logic [BYTE_W-1:0] STEP_RST  = BYTE_W'(1048576);
  localparam logic [TRIG_W-1:0] RAISE_RST = TRIG_W'(4);
  localparam logic [TRIG_W-1:0] LOWER_RST = TRIG_W'(12);
  localparam logic [BYTE_W-1:0] START_RST = BYTE_W'(4194304);

  typedef enum logic [1:0] {
    OUT_EMPTY = 2'd0,
    OUT_MISS  = 2'd1,
    OUT_HIT   = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ADJ_NONE  = 2'd0,
    ADJ_RAISE = 2'd1,
    ADJ_LOWER = 2'd2
  } adj_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_ROUND,
    ST_ADJ,
    ST_DONE
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic div_step;
    logic round;
    logic adjust;
    logic commit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

[sv/act_ctrl.sv]
// Sequencing state machine for one collection request at a time
module act_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  act_pkg::sts_t sts_i,
  output act_pkg::cmd_t cmd_o
);

  act_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= act_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      act_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = act_pkg::ST_EVAL;
        end
      end
      act_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.need_div ? act_pkg::ST_DIV : act_pkg::ST_ADJ;
      end
      act_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = act_pkg::ST_ROUND;
        end
      end
      act_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = act_pkg::ST_ADJ;
      end
      act_pkg::ST_ADJ: begin
        cmd_o.adjust = 1'b1;
        state_d      = act_pkg::ST_DONE;
      end
      act_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = act_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = act_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[sv/act_dp.sv]
// Datapath: configuration, history ring, threshold adaptation and result register
`include "adaptive_collection_threshold_defines.svh"

module act_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  act_pkg::cmd_t                     cmd_i,
  output act_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [act_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [act_pkg::BYTE_W-1:0]        cfg_data_i,
  input  logic [act_pkg::IN_TW-1:0]         in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [act_pkg::OUT_TW-1:0]        out_data_o
);

  localparam int BW = act_pkg::BYTE_W;

  // Configuration registers
  logic [1:0]                  cfg_mode_q;
  logic [BW-1:0]               cfg_min_q, cfg_max_q, cfg_step_q;
  logic [act_pkg::TRIG_W-1:0]  cfg_raise_q, cfg_lower_q;

  // Captured request
  logic                        force_q;
  logic [BW-1:0]               stat_q, total_q;

  // History and threshold state
  act_pkg::outcome_e           ring_q [act_pkg::HIST_DEPTH];
  logic [act_pkg::IDX_W-1:0]   idx_q;
  logic [act_pkg::CNT_W-1:0]   hit_cnt_q, miss_cnt_q;
  logic [act_pkg::CNT_W-1:0]   hit_cnt_d, miss_cnt_d;
  logic [BW-1:0]               live_q;

  // Adaptation plan and remainder unit
  logic                        plan_raise_q, plan_lower_q, plan_keep_q;
  logic [act_pkg::DIV_W-1:0]   t_q, t_d;
  logic [BW-1:0]               div_q, rem_q, rem_d;
  logic [act_pkg::BCNT_W-1:0]  bcnt_q;
  logic [act_pkg::M_W-1:0]     m_q, m_d;
  act_pkg::adj_e               adj_q;

  // Result register
  logic                        out_valid_q;
  logic                        out_col_q;
  logic [BW-1:0]               out_thr_q;
  logic [1:0]                  out_adj_q, out_rec_q;

  // Combinational terms
  logic                        active, hits_ok, misses_ok;
  logic [BW:0]                 tot_step, live_x, rem_sh;
  logic                        raise_go, lower_go, keep, rem_ge;
  logic [act_pkg::SUM_W-1:0]   cand;
  logic [BW-1:0]               raised, lv, lowered, live_adj;
  logic                        adj_any, collect, record;
  act_pkg::outcome_e           rec, old_ent;

  // Decide raise or lower from the running counts
  always_comb begin
    active    = (cfg_mode_q != act_pkg::MODE_ALWAYS);
    hits_ok   = act_pkg::CMP_W'(hit_cnt_q) >= act_pkg::CMP_W'(cfg_raise_q);
    misses_ok = act_pkg::CMP_W'(miss_cnt_q) >= act_pkg::CMP_W'(cfg_lower_q);
    tot_step  = {1'b0, total_q} + {1'b0, cfg_step_q};
    live_x    = {1'b0, live_q};
    raise_go  = active && hits_ok && (live_q < cfg_max_q);
    lower_go  = active && !hits_ok && misses_ok && (live_q > cfg_min_q) &&
                (live_x > tot_step);
    keep      = (cfg_step_q == '0) || (live_x >= tot_step);
    t_d       = tot_step - live_x;
  end

  // One restoring step of the remainder per cycle, MSB first
  always_comb begin
    rem_sh = {rem_q, t_q[bcnt_q]};
    rem_ge = rem_sh >= {1'b0, div_q};
    rem_d  = rem_ge ? BW'(rem_sh - {1'b0, div_q}) : rem_sh[BW-1:0];
  end

  // Round the gap up to a whole number of steps
  always_comb begin
    m_d = act_pkg::M_W'(t_q) - act_pkg::M_W'(rem_q) +
          ((rem_q != '0) ? act_pkg::M_W'(div_q) : act_pkg::M_W'(0));
  end

  // New threshold after raising or lowering
  always_comb begin
    cand     = act_pkg::SUM_W'(live_q) + act_pkg::SUM_W'(m_q);
    if (plan_keep_q) begin
      raised = live_q;
    end else if (cand > act_pkg::SUM_W'(cfg_max_q)) begin
      raised = cfg_max_q;
    end else begin
      raised = cand[BW-1:0];
    end
    lv       = live_q - cfg_step_q;
    lowered  = (lv < cfg_min_q) ? cfg_min_q : lv;
    live_adj = plan_raise_q ? raised : (plan_lower_q ? lowered : live_q);
    adj_any  = plan_raise_q || plan_lower_q;
  end

  // Outcome of the request against the settled threshold
  always_comb begin
    collect = force_q || (cfg_mode_q != act_pkg::MODE_BARRIER);
    record  = active && !collect;
    if (!record) begin
      rec = act_pkg::OUT_EMPTY;
    end else if (stat_q > live_q) begin
      rec = act_pkg::OUT_HIT;
    end else begin
      rec = act_pkg::OUT_MISS;
    end
    old_ent    = ring_q[idx_q];
    hit_cnt_d  = hit_cnt_q - act_pkg::CNT_W'(old_ent == act_pkg::OUT_HIT)
               + act_pkg::CNT_W'(rec == act_pkg::OUT_HIT);
    miss_cnt_d = miss_cnt_q - act_pkg::CNT_W'(old_ent == act_pkg::OUT_MISS)
               + act_pkg::CNT_W'(rec == act_pkg::OUT_MISS);
  end

  // Status to the controller
  always_comb begin
    sts_o.need_div = raise_go && !keep;
    sts_o.div_last = (bcnt_q == '0);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q  <= act_pkg::MODE_RST;
      cfg_min_q   <= act_pkg::MIN_RST;
      cfg_max_q   <= act_pkg::MAX_RST;
      cfg_step_q  <= act_pkg::STEP_RST;
      cfg_raise_q <= act_pkg::RAISE_RST;
      cfg_lower_q <= act_pkg::LOWER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        act_pkg::REG_MODE:  cfg_mode_q  <= cfg_data_i[1:0];
        act_pkg::REG_MIN:   cfg_min_q   <= cfg_data_i;
        act_pkg::REG_MAX:   cfg_max_q   <= cfg_data_i;
        act_pkg::REG_STEP:  cfg_step_q  <= cfg_data_i;
        act_pkg::REG_RAISE: cfg_raise_q <= cfg_data_i[act_pkg::TRIG_W-1:0];
        act_pkg::REG_LOWER: cfg_lower_q <= cfg_data_i[act_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  // Live threshold: adapted in the adjust step, loaded by a start write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= act_pkg::START_RST;
    end else if (cmd_i.adjust) begin
      live_q <= live_adj;
    end else if (cfg_we_i && (cfg_idx_i == act_pkg::REG_START)) begin
      live_q <= cfg_data_i;
    end
  end

  // History ring, write index and running counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q     <= '{default: act_pkg::OUT_EMPTY};
      idx_q      <= '0;
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmd_i.adjust && adj_any) begin
      ring_q     <= '{default: act_pkg::OUT_EMPTY};
      hit_cnt_q  <= '0;
      miss_cnt_q <= '0;
    end else if (cmd_i.commit && record) begin
      ring_q[idx_q] <= rec;
      hit_cnt_q     <= hit_cnt_d;
      miss_cnt_q    <= miss_cnt_d;
      if (idx_q == act_pkg::IDX_W'(act_pkg::HIST_DEPTH - 1)) begin
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Request capture, plan, remainder unit, rounding, adjustment code and result data
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      force_q <= in_data_i[0];
      stat_q  <= in_data_i[BW:1];
      total_q <= in_data_i[2*BW:BW+1];
    end
    if (cmd_i.eval) begin
      plan_raise_q <= raise_go;
      plan_lower_q <= lower_go;
      plan_keep_q  <= keep;
      t_q          <= t_d;
      div_q        <= cfg_step_q;
      rem_q        <= '0;
      bcnt_q       <= act_pkg::BCNT_W'(act_pkg::DIV_W - 1);
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      bcnt_q <= bcnt_q - 1'b1;
    end
    if (cmd_i.round) begin
      m_q <= m_d;
    end
    if (cmd_i.adjust) begin
      if (plan_raise_q) begin
        adj_q <= act_pkg::ADJ_RAISE;
      end else if (plan_lower_q) begin
        adj_q <= act_pkg::ADJ_LOWER;
      end else begin
        adj_q <= act_pkg::ADJ_NONE;
      end
    end
    if (cmd_i.commit) begin
      out_col_q <= collect || (rec == act_pkg::OUT_HIT);
      out_thr_q <= live_q;
      out_adj_q <= adj_q;
      out_rec_q <= rec;
    end
  end

  // Result valid: set on commit, drop once the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = act_pkg::OUT_TW'({out_rec_q, out_adj_q, out_thr_q, out_col_q});

  `ACT_ASSERT_IMP(a_cnt_bound, 1'b1, (act_pkg::CNT_W+1)'(hit_cnt_q) + (act_pkg::CNT_W+1)'(miss_cnt_q) <= (act_pkg::CNT_W+1)'(act_pkg::HIST_DEPTH), "hit and miss counts exceed ring depth")
  `ACT_ASSERT_IMP(a_rem_below_div, cmd_i.div_step, rem_q < div_q, "partial remainder not below step")
  `ACT_ASSERT_NXT(a_clear_on_adjust, cmd_i.adjust && adj_any, (hit_cnt_q == '0) && (miss_cnt_q == '0), "counts not cleared after adjustment")
  `ACT_ASSERT_NXT(a_lower_floor, cmd_i.adjust && plan_lower_q && !cfg_we_i, live_q >= cfg_min_q, "lowered threshold below minimum")

endmodule

[sv/adaptive_collection_threshold.sv]
// Top level of the adaptive collection threshold block
//
// Requests arrive on the s_axis channel, one transfer per collection request;
// each request yields exactly one decision transfer on m_axis, in order.
// Configuration is to be written through cfg_we_i / cfg_idx_i / cfg_data_i
// while the block is idle (the block does not enforce it); writing the start
// threshold also loads the live value. A raise by a computed number of
// steps adds the divide and round states between evaluate and adjust; the
// bit-serial remainder unit takes one bit of the 33-bit gap per cycle.
// One request is in flight at a time: s_axis_tready returns in the same
// cycle that the result appears in the output register, so a new request
// is taken only once the last is committed. The output register lets a
// finished result wait while the next request is taken; a stalled receiver
// holds only the final step. Reset clears the history ring, write index,
// counts and result valid, and restores all configuration registers and
// the live threshold defaults.
module adaptive_collection_threshold (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] force_req, [32:1] static_bytes, [64:33] total_bytes, rest zero
  input  logic [act_pkg::IN_TW-1:0]         s_axis_tdata,
  // Decision stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] collect_now, [32:1] threshold_now, [34:33] adjustment,
  // [36:35] recorded, rest zero
  output logic [act_pkg::OUT_TW-1:0]        m_axis_tdata,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [act_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [act_pkg::BYTE_W-1:0]        cfg_data_i
);

  act_pkg::cmd_t cmd;
  act_pkg::sts_t sts;

  // Sequencer
  act_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath
  act_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
